// ===== src/pcadj_pkg.sv =====
// Shared types and constants for the pixel color adjust block.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package pcadj_pkg;

    localparam int PIX_W      = 8;    // one color channel
    localparam int GAIN_W     = 15;   // unsigned gain registers
    localparam int MIX_W      = 13;   // unsigned fraction registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam int PIPE_STAGES = 7;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MIX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCANLINE   = 3'd4;

    // settings as seen by the datapath (gray already saturated to one)
    typedef struct packed {
        logic [GAIN_W-1:0] saturation;
        logic [GAIN_W-1:0] contrast;
        logic [GAIN_W-1:0] brightness;
        logic [MIX_W-1:0]  gray;
        logic              scan_on;
    } cfg_t;

endpackage

// ===== src/pcadj_cfg.sv =====
// Configuration registers and the settings derived from them.
// Depends on pcadj_pkg.
`timescale 1ns / 1ps

module pcadj_cfg #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pcadj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcadj_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pcadj_pkg::cfg_t                    cfg,
    output logic [FRACTION_BITS:0]             inv_gray,
    output logic [FRACTION_BITS:0]             scan_factor
);
    import pcadj_pkg::*;

    localparam int FW    = FRACTION_BITS + 1;
    localparam int ONE   = 1 << FRACTION_BITS;
    localparam int CMPW  = (FW > MIX_W) ? FW : MIX_W;
    localparam int SCANW = FRACTION_BITS + MIX_W;
    localparam int SCAN_K = ((32 << FRACTION_BITS) + 50) / 100;

    logic [GAIN_W-1:0] sat_reg, sat_next;
    logic [GAIN_W-1:0] con_reg, con_next;
    logic [GAIN_W-1:0] bri_reg, bri_next;
    logic [MIX_W-1:0]  gray_reg, gray_next;
    logic [MIX_W-1:0]  depth_reg, depth_next;
    logic [FW-1:0]     factor_reg, factor_next;
    logic [MIX_W-1:0]  gray_sat;
    logic [MIX_W-1:0]  depth_sat;
    logic [SCANW-1:0]  scan_prod;

    always_comb
    begin
        sat_next   = sat_reg;
        con_next   = con_reg;
        bri_next   = bri_reg;
        gray_next  = gray_reg;
        depth_next = depth_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SATURATION: sat_next   = cfg_data[GAIN_W-1:0];
                REG_CONTRAST:   con_next   = cfg_data[GAIN_W-1:0];
                REG_BRIGHTNESS: bri_next   = cfg_data[GAIN_W-1:0];
                REG_GRAY_MIX:   gray_next  = cfg_data[MIX_W-1:0];
                REG_SCANLINE:   depth_next = cfg_data[MIX_W-1:0];
                default:        ;
            endcase
        end
    end

    // saturate fractions to one
    always_comb
    begin
        gray_sat  = (CMPW'(gray_reg) > CMPW'(ONE)) ? MIX_W'(ONE) : gray_reg;
        depth_sat = (CMPW'(depth_reg) > CMPW'(ONE)) ? MIX_W'(ONE) : depth_reg;
        scan_prod = SCANW'(SCAN_K) * SCANW'(depth_sat);
        factor_next = FW'(ONE) - FW'(scan_prod >> FRACTION_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg    <= GAIN_W'(ONE);
            con_reg    <= GAIN_W'(ONE);
            bri_reg    <= GAIN_W'(ONE);
            gray_reg   <= '0;
            depth_reg  <= '0;
            factor_reg <= FW'(ONE);
        end
        else
        begin
            sat_reg    <= sat_next;
            con_reg    <= con_next;
            bri_reg    <= bri_next;
            gray_reg   <= gray_next;
            depth_reg  <= depth_next;
            factor_reg <= factor_next;
        end
    end

    assign cfg.saturation = sat_reg;
    assign cfg.contrast   = con_reg;
    assign cfg.brightness = bri_reg;
    assign cfg.gray       = gray_sat;
    assign cfg.scan_on    = (depth_reg != '0);
    assign inv_gray       = FW'(ONE) - FW'(gray_sat);
    assign scan_factor    = factor_reg;

`ifndef SYNTHESIS
    a_factor_off: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg == '0) |=> (factor_reg == FW'(ONE)))
        else $error("scanline factor not one with zero depth");
`endif

endmodule

// ===== src/pcadj_ctrl.sv =====
// Valid bits and per-stage advance enables of the pixel pipeline.
// Depends on pcadj_pkg.
`timescale 1ns / 1ps

module pcadj_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcadj_pkg::PIPE_STAGES-1:0]   stage_en,
    output logic [pcadj_pkg::PIPE_STAGES-1:0]   pipe_valid
);
    import pcadj_pkg::*;

    localparam int LAST = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] valid_reg, valid_next;

    // a stage advances when it is empty or its successor advances
    always_comb
    begin
        int i;
        stage_en[LAST] = !valid_reg[LAST] || m_tready;
        for (i = LAST - 1; i >= 0; i--)
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
    end

    always_comb
    begin
        int i;
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (i = 1; i < PIPE_STAGES; i++)
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready   = stage_en[0];
    assign m_tvalid   = valid_reg[LAST];
    assign pipe_valid = valid_reg;

endmodule

// ===== src/pcadj_luma.sv =====
// Luma of the pixel and its gray-mix share, shared by all three channels.
// Depends on pcadj_pkg.
`timescale 1ns / 1ps

module pcadj_luma #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                               clk,
    input  logic [2:0]                         stage_en,
    input  logic [pcadj_pkg::PIX_W-1:0]        red,
    input  logic [pcadj_pkg::PIX_W-1:0]        green,
    input  logic [pcadj_pkg::PIX_W-1:0]        blue,
    input  logic [pcadj_pkg::MIX_W-1:0]        gray,
    output logic [FRACTION_BITS+8:0]           luma0,
    output logic [FRACTION_BITS+8:0]           luma1,
    output logic [FRACTION_BITS+8:0]           luma_gray2
);
    import pcadj_pkg::*;

    localparam int LUMA_W = FRACTION_BITS + 9;
    localparam int PRODW  = LUMA_W + MIX_W;
    localparam int LUMA_R = ((2126 << FRACTION_BITS) + 5000) / 10000;
    localparam int LUMA_G = ((7152 << FRACTION_BITS) + 5000) / 10000;
    localparam int LUMA_B = ((722 << FRACTION_BITS) + 5000) / 10000;

    logic [LUMA_W-1:0] luma0_reg, luma0_next;
    logic [LUMA_W-1:0] luma1_reg;
    logic [LUMA_W-1:0] lg1_reg, lg1_next;
    logic [LUMA_W-1:0] lg2_reg;
    logic [PRODW-1:0]  lg_prod;

    always_comb
    begin
        luma0_next = LUMA_W'(LUMA_R) * LUMA_W'(red)
                   + LUMA_W'(LUMA_G) * LUMA_W'(green)
                   + LUMA_W'(LUMA_B) * LUMA_W'(blue);
        lg_prod    = PRODW'(luma0_reg) * PRODW'(gray);
        lg1_next   = lg_prod[FRACTION_BITS +: LUMA_W];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            luma0_reg <= luma0_next;
        if (stage_en[1])
        begin
            luma1_reg <= luma0_reg;
            lg1_reg   <= lg1_next;
        end
        if (stage_en[2])
            lg2_reg <= lg1_reg;
    end

    assign luma0      = luma0_reg;
    assign luma1      = luma1_reg;
    assign luma_gray2 = lg2_reg;

endmodule

// ===== src/pcadj_chan.sv =====
// Adjust chain of one color channel: saturation, gray mix, contrast,
// brightness, clamp and scanline. Depends on pcadj_pkg.
`timescale 1ns / 1ps

module pcadj_chan #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                                clk,
    input  logic [pcadj_pkg::PIPE_STAGES-1:0]   stage_en,
    input  logic [pcadj_pkg::PIX_W-1:0]         pix,
    input  logic [FRACTION_BITS+8:0]            luma0,
    input  logic [FRACTION_BITS+8:0]            luma1,
    input  logic [FRACTION_BITS+8:0]            luma_gray2,
    input  pcadj_pkg::cfg_t                     cfg,
    input  logic [FRACTION_BITS:0]              inv_gray,
    input  logic [FRACTION_BITS:0]              scan_factor,
    input  logic                                scan_sel,
    output logic [pcadj_pkg::PIX_W-1:0]         result
);
    import pcadj_pkg::*;

    localparam int FB   = FRACTION_BITS;
    localparam int GX   = (GAIN_W > FB) ? GAIN_W - FB : 0;
    localparam int DW   = FB + 10;
    localparam int P1W  = DW + GAIN_W + 1;
    localparam int V1W  = FB + 11 + GX;
    localparam int P2W  = V1W + FB + 2;
    localparam int V2W  = FB + 12 + GX;
    localparam int D3W  = V2W + 1;
    localparam int P3W  = D3W + GAIN_W + 1;
    localparam int V3W  = FB + 14 + 2 * GX;
    localparam int P4W  = V3W + GAIN_W + 1;
    localparam int V4W  = FB + 14 + 3 * GX;
    localparam int S5W  = FB + 9;
    localparam int MID  = (255 << FB) >> 1;

    logic [PIX_W-1:0]      c0_reg;
    logic signed [P1W-1:0] p1_reg, p1_next;
    logic signed [P2W-1:0] p2_reg, p2_next;
    logic signed [P3W-1:0] p3_reg, p3_next;
    logic signed [P4W-1:0] p4_reg, p4_next;
    logic [PIX_W-1:0]      b5_reg, b5_next;
    logic [S5W-1:0]        s5_reg, s5_next;
    logic [PIX_W-1:0]      out_reg, out_next;

    logic signed [DW-1:0]  diff1;
    logic signed [V1W-1:0] v1;
    logic signed [V2W-1:0] v2;
    logic signed [D3W-1:0] d3;
    logic signed [V3W-1:0] v3;
    logic signed [V4W-1:0] v4;
    logic [PIX_W:0]        scan_val;

    always_comb
    begin
        // chroma about luma, scaled by saturation
        diff1   = $signed({2'b00, c0_reg, {FB{1'b0}}}) - $signed({1'b0, luma0});
        p1_next = diff1 * $signed({1'b0, cfg.saturation});

        // blend toward luma
        v1      = V1W'(p1_reg >>> FB) + V1W'($signed({1'b0, luma1}));
        p2_next = v1 * $signed({1'b0, inv_gray});

        // contrast about mid-gray
        v2      = V2W'(p2_reg >>> FB) + V2W'($signed({1'b0, luma_gray2}));
        d3      = D3W'(v2) - D3W'(MID);
        p3_next = d3 * $signed({1'b0, cfg.contrast});

        // brightness
        v3      = V3W'(p3_reg >>> FB) + V3W'(MID);
        p4_next = v3 * $signed({1'b0, cfg.brightness});

        // clamp to a byte, drop the fraction
        v4 = V4W'(p4_reg >>> FB);
        if (v4[V4W-1])
            b5_next = '0;
        else if (|v4[V4W-2:FB+PIX_W])
            b5_next = '1;
        else
            b5_next = v4[FB +: PIX_W];
        s5_next = S5W'(b5_next) * S5W'(scan_factor);

        // darken odd rows
        scan_val = s5_reg[FB +: PIX_W+1];
        if (scan_sel)
            out_next = scan_val[PIX_W] ? '1 : scan_val[PIX_W-1:0];
        else
            out_next = b5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            c0_reg <= pix;
        if (stage_en[1])
            p1_reg <= p1_next;
        if (stage_en[2])
            p2_reg <= p2_next;
        if (stage_en[3])
            p3_reg <= p3_next;
        if (stage_en[4])
            p4_reg <= p4_next;
        if (stage_en[5])
        begin
            b5_reg <= b5_next;
            s5_reg <= s5_next;
        end
        if (stage_en[6])
            out_reg <= out_next;
    end

    assign result = out_reg;

endmodule

// ===== src/pixel_color_adjust.sv =====
// Top level of the pixel color adjust block: ports, row flag pipe, and
// the three channel chains. Depends on pcadj_pkg and all pcadj_* modules.
//
//  group  | dir | signals                              | item
//  s_*    | in  | tvalid tready tdata[23:0] tuser      | one RGB pixel + odd-row flag
//  m_*    | out | tvalid tready tdata[23:0]            | one adjusted RGB pixel
//  cfg_*  | in  | wr_en index[2:0] data[14:0]          | one register write
//
// One item per clock sustained while m_tready is high; each item passes, once it
// is accepted, through the input register, the four multiplies of the adjust
// chain, the clamp together with the scanline multiply, and the odd-row select.
// Reset clears all valid bits and loads the registers with unity gains,
// no gray mix and no scanline.
// A full stage holds only while its successor holds; a bubble is closed up,
// so input is taken while a result waits at the output if any stage is empty.
`timescale 1ns / 1ps

module pixel_color_adjust #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,    // red_in, green_in, blue_in
    input  logic                               s_tuser,    // row_is_odd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,    // red_out, green_out, blue_out
    input  logic                               cfg_wr_en,
    input  logic [pcadj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcadj_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcadj_pkg::*;

    localparam int LUMA_W   = FRACTION_BITS + 9;
    localparam int ODD_LAST = PIPE_STAGES - 2;

    cfg_t                   cfg;
    logic [FRACTION_BITS:0] inv_gray;
    logic [FRACTION_BITS:0] scan_factor;
    logic [PIPE_STAGES-1:0] stage_en;
    logic [PIPE_STAGES-1:0] pipe_valid;
    logic [LUMA_W-1:0]      luma0;
    logic [LUMA_W-1:0]      luma1;
    logic [LUMA_W-1:0]      luma_gray2;
    logic                   odd_reg [0:ODD_LAST];
    logic                   scan_sel;
    logic [PIX_W-1:0]       red_out;
    logic [PIX_W-1:0]       green_out;
    logic [PIX_W-1:0]       blue_out;

    pcadj_cfg #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .inv_gray    (inv_gray),
        .scan_factor (scan_factor)
    );

    pcadj_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stage_en   (stage_en),
        .pipe_valid (pipe_valid)
    );

    pcadj_luma #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_luma (
        .clk        (clk),
        .stage_en   (stage_en[2:0]),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .gray       (cfg.gray),
        .luma0      (luma0),
        .luma1      (luma1),
        .luma_gray2 (luma_gray2)
    );

    // carry the row flag alongside the channel chains
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            odd_reg[0] <= s_tuser;
        for (int i = 1; i <= ODD_LAST; i++)
        begin
            if (stage_en[i])
                odd_reg[i] <= odd_reg[i-1];
        end
    end

    assign scan_sel = odd_reg[ODD_LAST] && cfg.scan_on;

    pcadj_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_red (
        .clk         (clk),
        .stage_en    (stage_en),
        .pix         (s_tdata[7:0]),
        .luma0       (luma0),
        .luma1       (luma1),
        .luma_gray2  (luma_gray2),
        .cfg         (cfg),
        .inv_gray    (inv_gray),
        .scan_factor (scan_factor),
        .scan_sel    (scan_sel),
        .result      (red_out)
    );

    pcadj_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_green (
        .clk         (clk),
        .stage_en    (stage_en),
        .pix         (s_tdata[15:8]),
        .luma0       (luma0),
        .luma1       (luma1),
        .luma_gray2  (luma_gray2),
        .cfg         (cfg),
        .inv_gray    (inv_gray),
        .scan_factor (scan_factor),
        .scan_sel    (scan_sel),
        .result      (green_out)
    );

    pcadj_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_blue (
        .clk         (clk),
        .stage_en    (stage_en),
        .pix         (s_tdata[23:16]),
        .luma0       (luma0),
        .luma1       (luma1),
        .luma_gray2  (luma_gray2),
        .cfg         (cfg),
        .inv_gray    (inv_gray),
        .scan_factor (scan_factor),
        .scan_sel    (scan_sel),
        .result      (blue_out)
    );

    assign m_tdata = {blue_out, green_out, red_out};

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_valid[PIPE_STAGES-1] |-> s_tready)
        else $error("input blocked with empty output stage");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&pipe_valid) && !m_tready |-> !s_tready)
        else $error("input taken into a full stalled pipeline");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> pipe_valid[0])
        else $error("accepted item missing from first stage");
`endif

endmodule
